### sv/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg: shared constants and types of the 2x2 box downsampler
// Sizes of the line store, counters, lanes and configuration fields, plus the
// control bundle that the top level hands to each channel lane.
// ----------------------------------------------------------------------------
package mbd_pkg;

    // widest input row the line store is sized for (power of two, at most 4096)
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_ROWS    = 4096;

    localparam int LANES       = 4;      // red, green, blue, alpha
    localparam int PIX_W       = 8;
    localparam int PAIR_W      = PIX_W + 1;
    localparam int STORE_W     = LANES * PAIR_W;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int SLOT_W      = COL_W - 1;
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int ROW_W       = $clog2(MAX_ROWS);

    // configuration fields
    localparam int CFG_W       = 13;
    localparam int MODE_W      = 3;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_ROW_WIDTH    = 2'd0;
    localparam logic [1:0] REG_ROW_TOTAL    = 2'd1;
    localparam logic [1:0] REG_CHANNEL_MODE = 2'd2;

    // channel mode codes
    localparam logic [MODE_W-1:0] MODE_RGB  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RGBA = 3'd4;

    // per-transfer strobes for the channel lanes
    typedef struct packed {
        logic even_take;   // pixel on an even column: start a pair
        logic odd_take;    // pixel on an odd column: complete the pair
        logic s1_take;     // odd column of an odd row: quad goes to stage 1
    } mbd_lane_ctl_t;

endpackage

### sv/mbd_lane.sv
// ----------------------------------------------------------------------------
// mbd_lane: one color channel of the downsampler
// Keeps the horizontal pair sum, offers the completed pair to the line store
// and forms floor((above + pair) / 4) in stage 1.
// ----------------------------------------------------------------------------
module mbd_lane (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mbd_pkg::mbd_lane_ctl_t     ctl,
    input  logic [mbd_pkg::PIX_W-1:0]  pix_in,
    input  logic [mbd_pkg::PAIR_W-1:0] above_in,
    output logic [mbd_pkg::PAIR_W-1:0] pair_out,
    output logic [mbd_pkg::PIX_W-1:0]  avg_out
);

    logic [mbd_pkg::PAIR_W-1:0] pair_reg;
    logic [mbd_pkg::PAIR_W-1:0] s1_pair_reg;
    logic [mbd_pkg::PAIR_W:0]   total;

    // completed horizontal pair
    assign pair_out = pair_reg + {1'b0, pix_in};

    // pair register: loaded on even columns, takes the sum on odd columns
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg <= '0;
        end else if (ctl.even_take) begin
            pair_reg <= {1'b0, pix_in};
        end else if (ctl.odd_take) begin
            pair_reg <= pair_out;
        end
    end

    // stage 1 copy of the lower pair, lines up with the store read data
    always_ff @(posedge aclk) begin
        if (ctl.s1_take) begin
            s1_pair_reg <= pair_out;
        end
    end

    // quad average
    assign total   = {1'b0, above_in} + {1'b0, s1_pair_reg};
    assign avg_out = total[mbd_pkg::PAIR_W:2];

endmodule

### sv/mbd_line_store.sv
// ----------------------------------------------------------------------------
// mbd_line_store: line store of even-row pair sums
// One write port and one read port with registered read data; the read data
// holds until the next read.
// ----------------------------------------------------------------------------
module mbd_line_store (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [mbd_pkg::SLOT_W-1:0]  wr_addr,
    input  logic [mbd_pkg::STORE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [mbd_pkg::SLOT_W-1:0]  rd_addr,
    output logic [mbd_pkg::STORE_W-1:0] rd_data
);

    logic [mbd_pkg::STORE_W-1:0] mem [mbd_pkg::STORE_DEPTH];
    logic [mbd_pkg::STORE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/mipmap_box_downsample_2x2.sv
// ----------------------------------------------------------------------------
// mipmap_box_downsample_2x2: next mip level by 2x2 box averaging
// Raster-order RGB8/RGBA8 pixels in, one averaged pixel out per input quad.
// ----------------------------------------------------------------------------
// The block accepts one pixel every clock with no gaps as long as the result
// side keeps taking transfers. Each pixel on an odd column of an odd row
// completes a quad; that pixel's transfer loads stage 1 with the line store
// read of the pair sum from the row above, and stage 1 then hands the quad to
// the output register that drives the m_ side. The four channel lanes work in
// parallel, and the line store does at most one access (a write on even rows,
// a read on odd rows) per pixel. The store needs no clearing pass after reset.
// Configuration (row_width at 0x0, row_total at 0x4, channel_mode at 0x8) is
// to be written only while no pixel is in flight; m_frame_done marks the last
// output of a frame. The position counters wrap to the next frame at that
// frame's last pixel transfer.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_2x2 (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbd_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbd_pkg::DATA_W-1:0]  pwdata,
    output logic [mbd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // pixel input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [mbd_pkg::PIX_W-1:0]   s_red_in,
    input  logic [mbd_pkg::PIX_W-1:0]   s_green_in,
    input  logic [mbd_pkg::PIX_W-1:0]   s_blue_in,
    input  logic [mbd_pkg::PIX_W-1:0]   s_alpha_in,
    // averaged output
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mbd_pkg::PIX_W-1:0]   m_red_out,
    output logic [mbd_pkg::PIX_W-1:0]   m_green_out,
    output logic [mbd_pkg::PIX_W-1:0]   m_blue_out,
    output logic [mbd_pkg::PIX_W-1:0]   m_alpha_out,
    output logic                        m_frame_done
);

    localparam int CFG_W = mbd_pkg::CFG_W;

    // even-clear then saturate to 2..hi
    function automatic logic [CFG_W-1:0] clamp_even(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        r = {v[CFG_W-1:1], 1'b0};
        if (r < CFG_W'(2)) begin
            r = CFG_W'(2);
        end
        if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // configuration registers
    logic [CFG_W-1:0]          row_width_reg;
    logic [CFG_W-1:0]          row_total_reg;
    logic [mbd_pkg::MODE_W-1:0] channel_mode_reg;
    logic                      cfg_wr;

    // position counters
    logic [mbd_pkg::COL_W-1:0] column_pos_reg, column_pos_next;
    logic [mbd_pkg::ROW_W-1:0] row_pos_reg, row_pos_next;

    // stage 1 and output register
    logic                      s1_valid_reg, s1_done_reg, s1_rgb_reg;
    logic                      m_valid_reg;
    logic [mbd_pkg::PIX_W-1:0] out_reg [mbd_pkg::LANES];
    logic                      m_done_reg;

    logic [CFG_W-1:0]          width_eff, rows_eff;
    logic [CFG_W-1:0]          col_plus, row_plus;
    logic                      last_col, last_row, rgb_only;
    logic                      accept, adv, out_free;
    mbd_pkg::mbd_lane_ctl_t    lane_ctl;
    logic                      store_wr, store_rd;
    logic [mbd_pkg::SLOT_W-1:0] slot;

    logic [mbd_pkg::PIX_W-1:0]   pix [mbd_pkg::LANES];
    logic [mbd_pkg::PAIR_W-1:0]  lane_pair [mbd_pkg::LANES];
    logic [mbd_pkg::PIX_W-1:0]   lane_avg [mbd_pkg::LANES];
    logic [mbd_pkg::STORE_W-1:0] wr_data, rd_data;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg    <= CFG_W'(4096);
            row_total_reg    <= CFG_W'(4096);
            channel_mode_reg <= mbd_pkg::MODE_RGBA;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                mbd_pkg::REG_ROW_WIDTH:    row_width_reg    <= pwdata[CFG_W-1:0];
                mbd_pkg::REG_ROW_TOTAL:    row_total_reg    <= pwdata[CFG_W-1:0];
                mbd_pkg::REG_CHANNEL_MODE: channel_mode_reg <= pwdata[mbd_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            mbd_pkg::REG_ROW_WIDTH:    prdata = mbd_pkg::DATA_W'(row_width_reg);
            mbd_pkg::REG_ROW_TOTAL:    prdata = mbd_pkg::DATA_W'(row_total_reg);
            mbd_pkg::REG_CHANNEL_MODE: prdata = mbd_pkg::DATA_W'(channel_mode_reg);
            default:                   prdata = '0;
        endcase
    end

    // ---------------- frame geometry ----------------
    assign width_eff = clamp_even(row_width_reg, CFG_W'(mbd_pkg::MAX_WIDTH));
    assign rows_eff  = clamp_even(row_total_reg, CFG_W'(mbd_pkg::MAX_ROWS));
    assign col_plus  = CFG_W'(column_pos_reg) + CFG_W'(1);
    assign row_plus  = CFG_W'(row_pos_reg) + CFG_W'(1);
    assign last_col  = (col_plus >= width_eff);
    assign last_row  = (row_plus >= rows_eff);
    assign rgb_only  = (channel_mode_reg == mbd_pkg::MODE_RGB);
    assign slot      = column_pos_reg[mbd_pkg::COL_W-1:1];

    // ---------------- handshake and pipeline advance ----------------
    assign out_free = !m_valid_reg || m_ready;
    assign adv      = !s1_valid_reg || out_free;
    assign s_ready  = adv;
    assign accept   = s_valid && s_ready;

    assign lane_ctl.even_take = accept && !column_pos_reg[0];
    assign lane_ctl.odd_take  = accept && column_pos_reg[0];
    assign lane_ctl.s1_take   = accept && column_pos_reg[0] && row_pos_reg[0];
    assign store_wr = lane_ctl.odd_take && !row_pos_reg[0];
    assign store_rd = lane_ctl.s1_take;

    // position counters
    always_comb begin
        column_pos_next = column_pos_reg;
        row_pos_next    = row_pos_reg;
        if (accept) begin
            if (last_col) begin
                column_pos_next = '0;
                row_pos_next    = last_row ? '0 : row_pos_reg + 1'b1;
            end else begin
                column_pos_next = column_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_pos_reg <= '0;
            row_pos_reg    <= '0;
        end else begin
            column_pos_reg <= column_pos_next;
            row_pos_reg    <= row_pos_next;
        end
    end

    // ---------------- channel lanes ----------------
    assign pix[0] = s_red_in;
    assign pix[1] = s_green_in;
    assign pix[2] = s_blue_in;
    assign pix[3] = rgb_only ? '0 : s_alpha_in;

    for (genvar k = 0; k < mbd_pkg::LANES; k++) begin : g_lane
        mbd_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (lane_ctl),
            .pix_in   (pix[k]),
            .above_in (rd_data[k*mbd_pkg::PAIR_W +: mbd_pkg::PAIR_W]),
            .pair_out (lane_pair[k]),
            .avg_out  (lane_avg[k])
        );
        assign wr_data[k*mbd_pkg::PAIR_W +: mbd_pkg::PAIR_W] = lane_pair[k];
    end

    mbd_line_store u_store (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (slot),
        .wr_data (wr_data),
        .rd_en   (store_rd),
        .rd_addr (slot),
        .rd_data (rd_data)
    );

    // ---------------- stage 1 control ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= lane_ctl.s1_take;
        end
    end

    always_ff @(posedge aclk) begin
        if (lane_ctl.s1_take) begin
            s1_done_reg <= last_col && last_row;
            s1_rgb_reg  <= rgb_only;
        end
    end

    // ---------------- merge into output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_valid_reg) begin
            out_reg[0] <= lane_avg[0];
            out_reg[1] <= lane_avg[1];
            out_reg[2] <= lane_avg[2];
            out_reg[3] <= s1_rgb_reg ? '0 : lane_avg[3];
            m_done_reg <= s1_done_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red_out    = out_reg[0];
    assign m_green_out  = out_reg[1];
    assign m_blue_out   = out_reg[2];
    assign m_alpha_out  = out_reg[3];
    assign m_frame_done = m_done_reg;

`ifndef SYNTHESIS
    // a quad waiting behind a stalled output must block new pixels
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("pixel accepted while stage 1 is stalled");

    // the frame's final quad reaches stage 1 flagged as frame end
    a_frame_end_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_ctl.s1_take && last_col && last_row) |=> (s1_valid_reg && s1_done_reg))
        else $error("frame end quad not flagged in stage 1");

    // after the last column the position counter restarts at zero
    a_column_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_col) |=> (column_pos_reg == '0))
        else $error("column counter did not wrap");
`endif

endmodule

### dv/mipmap_box_downsample_2x2_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_box_downsample_2x2_test: self-checking bench for the 2x2 box filter
// Streams raster pixels through the downsampler under several row widths,
// heights and channel modes. The modes include out-of-range register values
// and settings changed partway through a frame. A bit-exact quad averager
// inside the bench predicts each output pixel and its frame-end flag, unless
// a directed row gives a hand-typed result. Each m_ side transfer is checked
// field by field. Both handshakes idle at random in rotating phases.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_2x2_test;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 8;        // margin after the last result drains
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SHAPE_PHASES   = 16;
    localparam int WIDE_PHASE     = 5;
    localparam int TALL_PHASE     = 11;
    localparam int EXTREME_PIXELS = 64;       // short run at either extreme
    localparam int DIRECTED_ROWS  = 24;
    localparam int HEAVY_PCT      = 52;
    localparam int LIGHT_PCT      = 10;

    // any code but RGB acts as RGBA
    localparam logic [mbd_pkg::MODE_W-1:0] MODE_OTHER = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_kind_t;

    typedef struct packed {
        logic [mbd_pkg::PIX_W-1:0] red;
        logic [mbd_pkg::PIX_W-1:0] green;
        logic [mbd_pkg::PIX_W-1:0] blue;
        logic [mbd_pkg::PIX_W-1:0] alpha;
        logic                      frame_end;
    } quad_avg_t;

    // per-pixel note: a hand-typed result overrides the predicted one
    typedef struct packed {
        logic      typed;
        quad_avg_t avg;
    } pixel_note_t;

    typedef struct packed {
        logic [mbd_pkg::CFG_W-1:0]  width;
        logic [mbd_pkg::CFG_W-1:0]  rows;
        logic [mbd_pkg::MODE_W-1:0] mode;
        logic [mbd_pkg::PIX_W-1:0]  red;
        logic [mbd_pkg::PIX_W-1:0]  green;
        logic [mbd_pkg::PIX_W-1:0]  blue;
        logic [mbd_pkg::PIX_W-1:0]  alpha;
        logic                       typed;
        quad_avg_t                  avg;
    } stim_row_t;

    // 2x2 frames first (every quad closes a frame), then RGB, then 4-wide
    // with an unknown mode code
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{2, 2, mbd_pkg::MODE_RGBA,   0,   0,   0,   0, 0, '0},
        '{2, 2, mbd_pkg::MODE_RGBA,   0,   0,   0,   0, 0, '0},
        '{2, 2, mbd_pkg::MODE_RGBA,   0,   0,   0,   0, 0, '0},
        '{2, 2, mbd_pkg::MODE_RGBA,   0,   0,   0,   0, 1, '{0, 0, 0, 0, 1}},
        '{2, 2, mbd_pkg::MODE_RGBA, 255, 255, 255, 255, 0, '0},
        '{2, 2, mbd_pkg::MODE_RGBA, 255, 255, 255, 255, 0, '0},
        '{2, 2, mbd_pkg::MODE_RGBA, 255, 255, 255, 255, 0, '0},
        '{2, 2, mbd_pkg::MODE_RGBA, 255, 255, 255, 255, 1, '{255, 255, 255, 255, 1}},
        '{2, 2, mbd_pkg::MODE_RGBA, 255,   0,   1, 128, 0, '0},
        '{2, 2, mbd_pkg::MODE_RGBA, 255,   0,   2, 128, 0, '0},
        '{2, 2, mbd_pkg::MODE_RGBA, 255,   0,   3, 128, 0, '0},
        '{2, 2, mbd_pkg::MODE_RGBA, 254,   3,   6, 127, 1, '{254, 0, 3, 127, 1}},
        '{2, 2, mbd_pkg::MODE_RGB,   10,  20,  30, 255, 0, '0},
        '{2, 2, mbd_pkg::MODE_RGB,   10,  20,  30, 255, 0, '0},
        '{2, 2, mbd_pkg::MODE_RGB,   10,  20,  30, 255, 0, '0},
        '{2, 2, mbd_pkg::MODE_RGB,   10,  20,  30, 255, 1, '{10, 20, 30, 0, 1}},
        '{4, 2, MODE_OTHER, 200,  17,  99, 250, 0, '0},
        '{4, 2, MODE_OTHER,   3, 180,  64,   1, 0, '0},
        '{4, 2, MODE_OTHER,  77,  77,   1, 254, 0, '0},
        '{4, 2, MODE_OTHER, 128, 255,   0,   9, 0, '0},
        '{4, 2, MODE_OTHER,   9,  33, 250,  66, 0, '0},
        '{4, 2, MODE_OTHER,   1,   2,   3,   4, 0, '0},
        '{4, 2, MODE_OTHER, 240,  16, 128,   8, 0, '0},
        '{4, 2, MODE_OTHER,  31, 222,  45, 190, 0, '0}
    };

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [mbd_pkg::ADDR_W-1:0]  paddr = '0;
    logic [mbd_pkg::DATA_W-1:0]  pwdata = '0;
    logic [mbd_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [mbd_pkg::PIX_W-1:0]   s_red_in = '0;
    logic [mbd_pkg::PIX_W-1:0]   s_green_in = '0;
    logic [mbd_pkg::PIX_W-1:0]   s_blue_in = '0;
    logic [mbd_pkg::PIX_W-1:0]   s_alpha_in = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [mbd_pkg::PIX_W-1:0]   m_red_out;
    logic [mbd_pkg::PIX_W-1:0]   m_green_out;
    logic [mbd_pkg::PIX_W-1:0]   m_blue_out;
    logic [mbd_pkg::PIX_W-1:0]   m_alpha_out;
    logic                        m_frame_done;

    int                 fail_count = 0;
    int                 cycle_count = 0;
    int                 gap_pct = 0;
    int                 stall_pct = 0;

    quad_avg_t          pending_avgs[$];
    pixel_note_t        pixel_notes[$];

    // averager state: line of pair sums, running pair, raster position
    logic [mbd_pkg::LANES-1:0][mbd_pkg::PAIR_W-1:0] line_pairs [mbd_pkg::STORE_DEPTH];
    logic [mbd_pkg::LANES-1:0][mbd_pkg::PAIR_W-1:0] run_pair = '0;
    int unsigned                  pix_col = 0;
    int unsigned                  pix_line = 0;
    logic [mbd_pkg::CFG_W-1:0]    width_reg = mbd_pkg::CFG_W'(mbd_pkg::MAX_WIDTH);
    logic [mbd_pkg::CFG_W-1:0]    height_reg = mbd_pkg::CFG_W'(mbd_pkg::MAX_ROWS);
    logic [mbd_pkg::MODE_W-1:0]   mode_reg = mbd_pkg::MODE_RGBA;

    mipmap_box_downsample_2x2 u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .s_alpha_in   (s_alpha_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_alpha_out  (m_alpha_out),
        .m_frame_done (m_frame_done)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // run-away guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // register value as the block uses it: even, then clipped to 2..hi
    function automatic int unsigned even_clamp(input int unsigned raw, input int unsigned hi);
        int unsigned v;
        v = raw & ~32'd1;
        if (v < 2) v = 2;
        if (v > hi) v = hi;
        return v;
    endfunction

    // one accepted pixel: update pair sums and position, maybe emit a quad average
    function automatic void box_average_step(
            input logic [mbd_pkg::LANES-1:0][mbd_pkg::PIX_W-1:0] px,
            output logic made, output quad_avg_t avg);
        int unsigned                                    w;
        int unsigned                                    h;
        int unsigned                                    slot;
        logic                                           rgb_only;
        logic                                           end_col;
        logic                                           end_line;
        logic [mbd_pkg::LANES-1:0][mbd_pkg::PAIR_W-1:0] lanes;
        logic [mbd_pkg::LANES-1:0][mbd_pkg::PAIR_W-1:0] above;
        logic [mbd_pkg::LANES-1:0][mbd_pkg::PAIR_W:0]   quad;
        w = even_clamp(width_reg, mbd_pkg::MAX_WIDTH);
        h = even_clamp(height_reg, mbd_pkg::MAX_ROWS);
        rgb_only = (mode_reg == mbd_pkg::MODE_RGB);
        end_col = (pix_col + 1 >= w);
        end_line = (pix_line + 1 >= h);
        slot = (pix_col >> 1) % mbd_pkg::STORE_DEPTH;
        made = 1'b0;
        avg = '0;
        for (int k = 0; k < mbd_pkg::LANES; k++) lanes[k] = {1'b0, px[k]};
        if (rgb_only) lanes[3] = '0;

        if ((pix_col & 1) == 0) begin
            run_pair = lanes;
        end else begin
            for (int k = 0; k < mbd_pkg::LANES; k++) run_pair[k] = run_pair[k] + lanes[k];
            if ((pix_line & 1) == 0) begin
                line_pairs[slot] = run_pair;
            end else begin
                above = line_pairs[slot];
                for (int k = 0; k < mbd_pkg::LANES; k++) quad[k] = above[k] + run_pair[k];
                avg.red = quad[0][mbd_pkg::PAIR_W:2];
                avg.green = quad[1][mbd_pkg::PAIR_W:2];
                avg.blue = quad[2][mbd_pkg::PAIR_W:2];
                avg.alpha = rgb_only ? '0 : quad[3][mbd_pkg::PAIR_W:2];
                avg.frame_end = end_col && end_line;
                made = 1'b1;
            end
        end

        // raster position, wrapping at row and frame end
        if (end_col) begin
            pix_col = 0;
            pix_line = end_line ? 0 : pix_line + 1;
        end else begin
            pix_col++;
        end
    endfunction

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            fail_count++;
        end
    endtask

    // observe register writes, pixel transfers and result transfers
    always @(posedge aclk) begin : observe
        pixel_note_t note;
        quad_avg_t   calc;
        quad_avg_t   want;
        logic        made;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    mbd_pkg::REG_ROW_WIDTH:    width_reg = pwdata[mbd_pkg::CFG_W-1:0];
                    mbd_pkg::REG_ROW_TOTAL:    height_reg = pwdata[mbd_pkg::CFG_W-1:0];
                    mbd_pkg::REG_CHANNEL_MODE: mode_reg = pwdata[mbd_pkg::MODE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                note = pixel_notes.pop_front();
                box_average_step({s_alpha_in, s_blue_in, s_green_in, s_red_in}, made, calc);
                if (made) pending_avgs.push_back(note.typed ? note.avg : calc);
            end
            if (m_valid && m_ready) begin
                if (pending_avgs.size() == 0) begin
                    $display("%0t: unexpected output transfer, expected none, got %h %h %h %h %b",
                             $time, m_red_out, m_green_out, m_blue_out, m_alpha_out,
                             m_frame_done);
                    fail_count++;
                end else begin
                    want = pending_avgs.pop_front();
                    check_field("red", want.red, m_red_out);
                    check_field("green", want.green, m_green_out);
                    check_field("blue", want.blue, m_blue_out);
                    check_field("alpha", want.alpha, m_alpha_out);
                    check_field("frame_done", want.frame_end, m_frame_done);
                end
            end
        end
    end

    task automatic set_idling(input idle_kind_t kind);
        case (kind)
            IDLE_NONE: begin gap_pct = 0;         stall_pct = 0;         end
            IDLE_SEND: begin gap_pct = HEAVY_PCT; stall_pct = 0;         end
            IDLE_RECV: begin gap_pct = 0;         stall_pct = HEAVY_PCT; end
            default:   begin gap_pct = LIGHT_PCT; stall_pct = LIGHT_PCT; end
        endcase
    endtask

    // drive one pixel and hold it until the transfer
    task automatic send_pixel(input logic [mbd_pkg::PIX_W-1:0] r, g, b, a,
                              input logic typed, input quad_avg_t avg);
        int          gap;
        pixel_note_t note;
        gap = 0;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        note.typed = typed;
        note.avg = avg;
        pixel_notes.push_back(note);
        s_valid <= 1'b1;
        s_red_in <= r;
        s_green_in <= g;
        s_blue_in <= b;
        s_alpha_in <= a;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [mbd_pkg::PIX_W-1:0] rand_channel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return mbd_pkg::PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random();
        send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(), 1'b0, '0);
    endtask

    // stop the stream and let every pending result drain
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_avgs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [mbd_pkg::DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // read a register back and compare
    task automatic verify_reg(input logic [1:0] idx, input logic [mbd_pkg::DATA_W-1:0] want);
        logic [mbd_pkg::DATA_W-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (got !== want) begin
            $display("%0t: register %0d read mismatch, expected %0d, got %0d",
                     $time, idx, want, got);
            fail_count++;
        end
    endtask

    task automatic apply_setting(input logic [mbd_pkg::CFG_W-1:0] w, h,
                                 input logic [mbd_pkg::MODE_W-1:0] m);
        settle();
        reg_write(mbd_pkg::REG_ROW_WIDTH, mbd_pkg::DATA_W'(w));
        reg_write(mbd_pkg::REG_ROW_TOTAL, mbd_pkg::DATA_W'(h));
        reg_write(mbd_pkg::REG_CHANNEL_MODE, mbd_pkg::DATA_W'(m));
        verify_reg(mbd_pkg::REG_ROW_WIDTH, mbd_pkg::DATA_W'(w));
        verify_reg(mbd_pkg::REG_ROW_TOTAL, mbd_pkg::DATA_W'(h));
        verify_reg(mbd_pkg::REG_CHANNEL_MODE, mbd_pkg::DATA_W'(m));
    endtask

    initial begin
        logic [mbd_pkg::CFG_W-1:0]  w;
        logic [mbd_pkg::CFG_W-1:0]  h;
        logic [mbd_pkg::MODE_W-1:0] m;
        logic [mbd_pkg::CFG_W-1:0]  cur_w;
        logic [mbd_pkg::CFG_W-1:0]  cur_h;
        logic [mbd_pkg::MODE_W-1:0] cur_m;
        int                         n;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values
        verify_reg(mbd_pkg::REG_ROW_WIDTH, mbd_pkg::DATA_W'(mbd_pkg::MAX_WIDTH));
        verify_reg(mbd_pkg::REG_ROW_TOTAL, mbd_pkg::DATA_W'(mbd_pkg::MAX_ROWS));
        verify_reg(mbd_pkg::REG_CHANNEL_MODE, mbd_pkg::DATA_W'(mbd_pkg::MODE_RGBA));
        cur_w = mbd_pkg::CFG_W'(mbd_pkg::MAX_WIDTH);
        cur_h = mbd_pkg::CFG_W'(mbd_pkg::MAX_ROWS);
        cur_m = mbd_pkg::MODE_RGBA;

        // directed table
        set_idling(IDLE_BOTH);
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (DIRECTED[i].width != cur_w || DIRECTED[i].rows != cur_h ||
                DIRECTED[i].mode != cur_m) begin
                cur_w = DIRECTED[i].width;
                cur_h = DIRECTED[i].rows;
                cur_m = DIRECTED[i].mode;
                apply_setting(cur_w, cur_h, cur_m);
            end
            send_pixel(DIRECTED[i].red, DIRECTED[i].green, DIRECTED[i].blue,
                       DIRECTED[i].alpha, DIRECTED[i].typed, DIRECTED[i].avg);
        end

        // random phases; settings change only on an even row so that no odd row
        // is split between two settings
        for (int ph = 0; ph < SHAPE_PHASES; ph++) begin
            set_idling(idle_kind_t'(ph % 4));
            if (ph == WIDE_PHASE) begin
                w = '1;                          // clips to the widest row
                h = mbd_pkg::CFG_W'(1);          // clips to two rows
                m = mbd_pkg::MODE_RGB;
                n = EXTREME_PIXELS;
            end else if (ph == TALL_PHASE) begin
                w = '0;
                h = mbd_pkg::CFG_W'(mbd_pkg::MAX_ROWS);
                m = mbd_pkg::MODE_RGBA;
                n = EXTREME_PIXELS;
            end else begin
                case ($urandom_range(9))
                    0:       w = mbd_pkg::CFG_W'($urandom_range(1));
                    1:       w = mbd_pkg::CFG_W'(2 * $urandom_range(12) + 1);
                    2:       w = mbd_pkg::CFG_W'(2 * $urandom_range(3, 10));
                    default: w = mbd_pkg::CFG_W'(1 << $urandom_range(1, 5));
                endcase
                case ($urandom_range(7))
                    0:       h = mbd_pkg::CFG_W'($urandom_range(1));
                    1:       h = mbd_pkg::CFG_W'(2 * $urandom_range(7) + 1);
                    default: h = mbd_pkg::CFG_W'(2 * $urandom_range(1, 6));
                endcase
                if ($urandom_range(3) == 0) m = mbd_pkg::MODE_W'($urandom_range(7));
                else m = $urandom_range(1) ? mbd_pkg::MODE_RGB : mbd_pkg::MODE_RGBA;
                n = $urandom_range(50, 100);
            end
            apply_setting(w, h, m);
            repeat (n) send_random();
            // finish an odd row so the phase ends on an even one
            settle();
            if ((pix_line & 1) != 0) begin
                repeat (even_clamp(width_reg, mbd_pkg::MAX_WIDTH) - pix_col) send_random();
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
